[src/l3rw_pkg.sv]
// ----------------------------------------------------------------------------
// l3rw_pkg
// types, codes and constants shared by the header rewrite block
// ----------------------------------------------------------------------------
package l3rw_pkg;

	localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
	localparam logic [7:0]  PROTO_TCP      = 8'd6;
	localparam logic [15:0] MIN_FRAME      = 16'd34;

	localparam int QUEUE_DEPTH_DEF = 4;
	localparam int ADDR_W          = 6;
	localparam int CFG_DW          = 64;
	localparam int PART_W          = 19;
	localparam int SUM_W           = 20;

	typedef enum logic [2:0] {
		REG_CLIENT_ADDR      = 3'd0,
		REG_CLIENT_HW_ADDR   = 3'd1,
		REG_BACKEND_ADDR     = 3'd2,
		REG_BACKEND_HW_ADDR  = 3'd3,
		REG_BALANCER_ADDR    = 3'd4,
		REG_BALANCER_HW_ADDR = 3'd5
	} reg_idx_t;

	typedef enum logic [1:0] {
		CLS_PASS       = 2'd0,
		CLS_TO_BACKEND = 2'd1,
		CLS_TO_CLIENT  = 2'd2
	} cls_t;

	typedef struct packed {
		logic [31:0] client_addr;
		logic [47:0] client_hw_addr;
		logic [31:0] backend_addr;
		logic [47:0] backend_hw_addr;
		logic [31:0] balancer_addr;
		logic [47:0] balancer_hw_addr;
	} cfg_t;

	// first member sits in the highest bits
	typedef struct packed {
		logic [31:0] ip_dest;
		logic [31:0] ip_source;
		logic [31:0] ip_word_two;
		logic [31:0] ip_word_one;
		logic [31:0] ip_word_zero;
		logic [15:0] ether_type;
		logic [47:0] in_src_mac;
		logic [47:0] in_dst_mac;
		logic [15:0] frame_length;
	} in_item_t;

	typedef struct packed {
		logic [15:0] out_checksum;
		logic [31:0] out_dest;
		logic [31:0] out_source;
		logic [47:0] out_src_mac;
		logic [47:0] out_dst_mac;
	} out_item_t;

	typedef struct packed {
		cls_t              cls;
		logic [47:0]       dst_mac;
		logic [47:0]       src_mac;
		logic [31:0]       ip_source;
		logic [31:0]       ip_dest;
		logic [15:0]       checksum;
		logic [PART_W-1:0] part_sum;
	} q_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	localparam int IN_W  = $bits(in_item_t);
	localparam int OUT_W = $bits(out_item_t);

endpackage

[src/l3rw_regs.sv]
// ----------------------------------------------------------------------------
// l3rw_regs
// apb register file holding the addresses and macs of the three parties
// ----------------------------------------------------------------------------
module l3rw_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [l3rw_pkg::ADDR_W-1:0]   paddr,
	input  logic [l3rw_pkg::CFG_DW-1:0]   pwdata,
	output logic [l3rw_pkg::CFG_DW-1:0]   prdata,
	output logic                          pready,
	output l3rw_pkg::cfg_t                cfg
);

	l3rw_pkg::cfg_t     cfg_q;
	l3rw_pkg::reg_idx_t idx;
	logic               wr_en;

	assign idx    = l3rw_pkg::reg_idx_t'(paddr[5:3]);
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (idx)
				l3rw_pkg::REG_CLIENT_ADDR:      cfg_q.client_addr      <= pwdata[31:0];
				l3rw_pkg::REG_CLIENT_HW_ADDR:   cfg_q.client_hw_addr   <= pwdata[47:0];
				l3rw_pkg::REG_BACKEND_ADDR:     cfg_q.backend_addr     <= pwdata[31:0];
				l3rw_pkg::REG_BACKEND_HW_ADDR:  cfg_q.backend_hw_addr  <= pwdata[47:0];
				l3rw_pkg::REG_BALANCER_ADDR:    cfg_q.balancer_addr    <= pwdata[31:0];
				l3rw_pkg::REG_BALANCER_HW_ADDR: cfg_q.balancer_hw_addr <= pwdata[47:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			l3rw_pkg::REG_CLIENT_ADDR:      prdata = {32'd0, cfg_q.client_addr};
			l3rw_pkg::REG_CLIENT_HW_ADDR:   prdata = {16'd0, cfg_q.client_hw_addr};
			l3rw_pkg::REG_BACKEND_ADDR:     prdata = {32'd0, cfg_q.backend_addr};
			l3rw_pkg::REG_BACKEND_HW_ADDR:  prdata = {16'd0, cfg_q.backend_hw_addr};
			l3rw_pkg::REG_BALANCER_ADDR:    prdata = {32'd0, cfg_q.balancer_addr};
			l3rw_pkg::REG_BALANCER_HW_ADDR: prdata = {16'd0, cfg_q.balancer_hw_addr};
			default:                        prdata = '0;
		endcase
	end

endmodule

[src/l3rw_front.sv]
// ----------------------------------------------------------------------------
// l3rw_front
// accepts headers, classifies them and starts the checksum sum
// ----------------------------------------------------------------------------
module l3rw_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [l3rw_pkg::IN_W-1:0]   s_tdata,
	input  l3rw_pkg::cfg_t              cfg,
	input  l3rw_pkg::q_status_t         q_status,
	output logic                        push,
	output l3rw_pkg::q_entry_t          push_entry
);

	l3rw_pkg::in_item_t  item;
	l3rw_pkg::cls_t      cls;
	l3rw_pkg::q_entry_t  entry_d;
	l3rw_pkg::q_entry_t  entry_s1;
	logic                valid_s1;
	logic                eligible;
	logic                take;

	assign item     = l3rw_pkg::in_item_t'(s_tdata);
	assign s_tready = !valid_s1 || !q_status.full;
	assign take     = s_tvalid && s_tready;
	assign push     = valid_s1 && !q_status.full;
	assign push_entry = entry_s1;

	assign eligible = (item.frame_length >= l3rw_pkg::MIN_FRAME)
		&& (item.ether_type == l3rw_pkg::ETHERTYPE_IPV4)
		&& (item.ip_word_two[23:16] == l3rw_pkg::PROTO_TCP);

	always_comb begin
		if (!eligible) begin
			cls = l3rw_pkg::CLS_PASS;
		end else if (item.ip_source == cfg.client_addr) begin
			cls = l3rw_pkg::CLS_TO_BACKEND;
		end else if (item.ip_source == cfg.backend_addr) begin
			cls = l3rw_pkg::CLS_TO_CLIENT;
		end else begin
			cls = l3rw_pkg::CLS_PASS;
		end
	end

	// header words that the rewrite leaves alone, check field zeroed
	always_comb begin
		entry_d.cls       = cls;
		entry_d.dst_mac   = item.in_dst_mac;
		entry_d.src_mac   = item.in_src_mac;
		entry_d.ip_source = item.ip_source;
		entry_d.ip_dest   = item.ip_dest;
		entry_d.checksum  = item.ip_word_two[15:0];
		entry_d.part_sum  = l3rw_pkg::PART_W'(item.ip_word_zero[31:16])
			+ l3rw_pkg::PART_W'(item.ip_word_zero[15:0])
			+ l3rw_pkg::PART_W'(item.ip_word_one[31:16])
			+ l3rw_pkg::PART_W'(item.ip_word_one[15:0])
			+ l3rw_pkg::PART_W'(item.ip_word_two[31:16]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			entry_s1 <= entry_d;
		end
	end

endmodule

[src/l3rw_fifo.sv]
// ----------------------------------------------------------------------------
// l3rw_fifo
// short queue between classification and rewrite, depth a power of two
// ----------------------------------------------------------------------------
module l3rw_fifo #(
	parameter int DEPTH = l3rw_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  l3rw_pkg::q_entry_t   push_entry,
	input  logic                 pop,
	output l3rw_pkg::q_entry_t   pop_entry,
	output l3rw_pkg::q_status_t  status
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	l3rw_pkg::q_entry_t mem [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign status.full  = (count_q == CNT_W'(DEPTH));
	assign status.empty = (count_q == '0);
	assign pop_entry    = mem[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_entry;
		end
	end

endmodule

[src/l3rw_back.sv]
// ----------------------------------------------------------------------------
// l3rw_back
// applies the rewrite, finishes the header checksum, holds the result
// ----------------------------------------------------------------------------
module l3rw_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  l3rw_pkg::cfg_t               cfg,
	input  l3rw_pkg::q_status_t          q_status,
	input  l3rw_pkg::q_entry_t           pop_entry,
	output logic                         pop,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [l3rw_pkg::OUT_W-1:0]   m_tdata,
	output logic [0:0]                   m_tuser
);

	l3rw_pkg::out_item_t      res_d;
	l3rw_pkg::out_item_t      res_q;
	logic                     hit;
	logic                     hit_q;
	logic                     out_valid_q;
	logic [31:0]              new_dst;
	logic [47:0]              new_dmac;
	logic [l3rw_pkg::SUM_W-1:0] sum;
	logic [16:0]              fold1;
	logic [16:0]              fold2;

	assign pop      = !q_status.empty && (!out_valid_q || m_tready);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = res_q;
	assign m_tuser  = hit_q;

	always_comb begin
		case (pop_entry.cls)
			l3rw_pkg::CLS_TO_BACKEND: begin
				hit      = 1'b1;
				new_dst  = cfg.backend_addr;
				new_dmac = cfg.backend_hw_addr;
			end
			l3rw_pkg::CLS_TO_CLIENT: begin
				hit      = 1'b1;
				new_dst  = cfg.client_addr;
				new_dmac = cfg.client_hw_addr;
			end
			default: begin
				hit      = 1'b0;
				new_dst  = pop_entry.ip_dest;
				new_dmac = pop_entry.dst_mac;
			end
		endcase
	end

	always_comb begin
		sum = l3rw_pkg::SUM_W'(pop_entry.part_sum)
			+ l3rw_pkg::SUM_W'(cfg.balancer_addr[31:16])
			+ l3rw_pkg::SUM_W'(cfg.balancer_addr[15:0])
			+ l3rw_pkg::SUM_W'(new_dst[31:16])
			+ l3rw_pkg::SUM_W'(new_dst[15:0]);
		fold1 = {1'b0, sum[15:0]} + {13'd0, sum[19:16]};
		fold2 = {1'b0, fold1[15:0]} + {16'd0, fold1[16]};
	end

	always_comb begin
		res_d.out_dst_mac = new_dmac;
		if (hit) begin
			res_d.out_src_mac  = cfg.balancer_hw_addr;
			res_d.out_source   = cfg.balancer_addr;
			res_d.out_dest     = new_dst;
			res_d.out_checksum = ~fold2[15:0];
		end else begin
			res_d.out_src_mac  = pop_entry.src_mac;
			res_d.out_source   = pop_entry.ip_source;
			res_d.out_dest     = pop_entry.ip_dest;
			res_d.out_checksum = pop_entry.checksum;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_q <= res_d;
			hit_q <= hit;
		end
	end

endmodule

[src/l3rw_packet_rewrite_lb_core.sv]
// ----------------------------------------------------------------------------
// l3_packet_rewrite_lb_core
// ipv4 nat rewrite for a two-party load balancer with header checksum
// ----------------------------------------------------------------------------
// One header enters per cycle and one result leaves per cycle in steady
// state while the output side is not held off. An accepted header is
// classified into the front stage register, then written to the queue and
// then taken into the output register. The queue of QUEUE_DEPTH entries
// lets the input side keep taking headers while the output side is held
// off; once it and both stage registers are full, s_tready drops. TCP
// over IPv4 frames of at least 34 bytes from the client go to the backend,
// from the backend to the client, with the balancer as new source;
// everything else passes as is. Registers sit at byte address 8*i; the user
// must see they are written only while idle; the block does not check.
module l3_packet_rewrite_lb_core #(
	parameter int QUEUE_DEPTH = l3rw_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [l3rw_pkg::ADDR_W-1:0]  paddr,
	input  logic [l3rw_pkg::CFG_DW-1:0]  pwdata,
	output logic [l3rw_pkg::CFG_DW-1:0]  prdata,
	output logic                         pready,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	// frame_length, in_dst_mac, in_src_mac, ether_type, ip_word_zero,
	// ip_word_one, ip_word_two, ip_source, ip_dest
	input  logic [l3rw_pkg::IN_W-1:0]    s_tdata,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// out_dst_mac, out_src_mac, out_source, out_dest, out_checksum
	output logic [l3rw_pkg::OUT_W-1:0]   m_tdata,
	// action
	output logic [0:0]                   m_tuser
);

	l3rw_pkg::cfg_t      cfg;
	l3rw_pkg::q_status_t q_status;
	l3rw_pkg::q_entry_t  push_entry;
	l3rw_pkg::q_entry_t  pop_entry;
	logic                push;
	logic                pop;

	l3rw_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	l3rw_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.cfg        (cfg),
		.q_status   (q_status),
		.push       (push),
		.push_entry (push_entry)
	);

	l3rw_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.pop_entry  (pop_entry),
		.status     (q_status)
	);

	l3rw_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.q_status  (q_status),
		.pop_entry (pop_entry),
		.pop       (pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	a_push_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_status.full)
		else $error("queue written while full");

	a_pop_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_status.empty)
		else $error("queue read while empty");

	a_full_stalls_input: assert property (@(posedge clk) disable iff (!arst_n)
		(q_status.full && !s_tready) |=> !m_tvalid || $past(m_tvalid))
		else $error("input stalled on a full queue with no result held");

	a_status_sane: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_status.full && q_status.empty))
		else $error("queue reports full and empty at once");

endmodule
